// ===== rtl/psb_pkg.sv =====
// shared types, constants and action codes for the ping-pong sample buffer
package psb_pkg;

    localparam int BLOCK_LEN  = 64;
    localparam int BANK_DEPTH = 64;
    localparam int POS_W      = $clog2(BANK_DEPTH);
    localparam int CNT_W      = POS_W + 1;

    typedef enum logic [1:0] {
        ACT_PUT    = 2'd0,
        ACT_FETCH  = 2'd1,
        ACT_STATUS = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [15:0] sample;
    } t_in_word;

    typedef struct packed {
        logic signed [15:0] sample_out;
        logic               available;
        logic               last_sample;
        logic               overflow_flag;
    } t_out_word;

    typedef struct packed {
        logic put;
        logic start_fetch;
        logic emit_single;
        logic clear_ovr;
        logic issue;
        logic move;
    } t_cmd;

    typedef struct packed {
        logic block_ready;
        logic overrun;
        logic rd_vld;
        logic rd_done;
        logic out_busy;
    } t_sts;

endpackage

// ===== rtl/psb_ctrl.sv =====
// controller: decodes accepted words and sequences the block readout
module psb_ctrl
    import psb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_action,
    input  t_sts       i_sts,
    output logic       o_in_stall,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_FETCH = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   accept;
    logic   rd_free;

    assign o_in_stall = (r_state != S_IDLE) || i_sts.out_busy;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        rd_free = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (t_action'(i_action))
                        ACT_PUT: begin
                            o_cmd.put = !i_sts.overrun;
                        end
                        ACT_FETCH: begin
                            if (i_sts.block_ready) begin
                                o_cmd.start_fetch = 1'b1;
                                n_state           = S_FETCH;
                            end else begin
                                o_cmd.emit_single = 1'b1;
                            end
                        end
                        ACT_STATUS: begin
                            o_cmd.emit_single = 1'b1;
                            o_cmd.clear_ovr   = 1'b1;
                        end
                        ACT_NONE: begin
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_FETCH: begin
                o_cmd.move  = i_sts.rd_vld && !i_sts.out_busy;
                rd_free     = !i_sts.rd_vld || o_cmd.move;
                o_cmd.issue = !i_sts.rd_done && rd_free;
                // leave once every sample is read and the read stage drains
                if (i_sts.rd_done && rd_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_issue_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.issue |-> !i_sts.rd_done)
        else $error("read issued past end of block");

    a_move_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.move |-> i_sts.rd_vld)
        else $error("move without read data");

    a_single_free_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit_single |-> (!i_sts.out_busy && !i_sts.rd_vld))
        else $error("single word loaded over a busy output");

    a_fetch_needs_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start_fetch |=> !i_sts.block_ready)
        else $error("ready not cleared after fetch start");

endmodule

// ===== rtl/psb_datapath.sv =====
// datapath: two-bank sample memory, write pointer, flags, read and output stages
module psb_datapath
    import psb_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    input  logic signed [15:0] i_sample,
    input  logic               i_out_stall,
    output t_sts               o_sts,
    output logic               o_out_valid,
    output t_out_word          o_out_word
);

    localparam logic [CNT_W-1:0] LEN_C  = CNT_W'(BLOCK_LEN);
    localparam logic [CNT_W-1:0] LAST_C = CNT_W'(BLOCK_LEN - 1);

    logic [15:0] r_mem [2*BANK_DEPTH];

    logic [POS_W-1:0] r_wr_pos, n_wr_pos;
    logic             r_wr_bank, n_wr_bank;
    logic             r_ready, n_ready;
    logic             r_ovr, n_ovr;
    logic [CNT_W-1:0] r_rd_idx, n_rd_idx;
    logic             r_rd_bank, n_rd_bank;
    logic             r_rd_vld, n_rd_vld;
    logic             r_out_valid, n_out_valid;
    logic [15:0]      r_rd_data;
    logic             r_rd_last;
    t_out_word        r_out_word;
    logic [CNT_W-1:0] next_pos;
    logic             wrap;

    assign next_pos = {1'b0, r_wr_pos} + CNT_W'(1);
    assign wrap     = (next_pos >= LEN_C);

    always_comb begin
        n_wr_pos    = r_wr_pos;
        n_wr_bank   = r_wr_bank;
        n_ready     = r_ready;
        n_ovr       = r_ovr;
        n_rd_idx    = r_rd_idx;
        n_rd_bank   = r_rd_bank;
        n_rd_vld    = r_rd_vld;
        n_out_valid = r_out_valid;
        if (i_cmd.put) begin
            if (wrap) begin
                n_wr_pos  = '0;
                n_wr_bank = !r_wr_bank;
                if (r_ready) begin
                    n_ovr = 1'b1;
                end else begin
                    n_ready = 1'b1;
                end
            end else begin
                n_wr_pos = next_pos[POS_W-1:0];
            end
        end
        if (i_cmd.clear_ovr) begin
            n_ovr = 1'b0;
        end
        if (i_cmd.start_fetch) begin
            n_ready  = 1'b0;
            n_rd_idx = '0;
            // just-filled bank, or the older one when overrun
            n_rd_bank = (r_wr_bank != r_ovr) ? 1'b0 : 1'b1;
        end
        if (i_cmd.issue) begin
            n_rd_idx = r_rd_idx + CNT_W'(1);
            n_rd_vld = 1'b1;
        end else if (i_cmd.move) begin
            n_rd_vld = 1'b0;
        end
        if (i_cmd.move || i_cmd.emit_single) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pos    <= '0;
            r_wr_bank   <= 1'b0;
            r_ready     <= 1'b0;
            r_ovr       <= 1'b0;
            r_rd_idx    <= LEN_C;
            r_rd_bank   <= 1'b0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_pos    <= n_wr_pos;
            r_wr_bank   <= n_wr_bank;
            r_ready     <= n_ready;
            r_ovr       <= n_ovr;
            r_rd_idx    <= n_rd_idx;
            r_rd_bank   <= n_rd_bank;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_mem[{r_wr_bank, r_wr_pos}] <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_rd_data <= r_mem[{r_rd_bank, r_rd_idx[POS_W-1:0]}];
            r_rd_last <= (r_rd_idx == LAST_C);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.move) begin
            r_out_word.sample_out    <= r_rd_data;
            r_out_word.available     <= 1'b1;
            r_out_word.last_sample   <= r_rd_last;
            r_out_word.overflow_flag <= 1'b0;
        end else if (i_cmd.emit_single) begin
            r_out_word.sample_out    <= '0;
            r_out_word.available     <= 1'b0;
            r_out_word.last_sample   <= 1'b1;
            r_out_word.overflow_flag <= i_cmd.clear_ovr && r_ovr;
        end
    end

    assign o_sts.block_ready = r_ready;
    assign o_sts.overrun     = r_ovr;
    assign o_sts.rd_vld      = r_rd_vld;
    assign o_sts.rd_done     = (r_rd_idx == LEN_C);
    assign o_sts.out_busy    = r_out_valid && i_out_stall;
    assign o_out_valid       = r_out_valid;
    assign o_out_word        = r_out_word;

    a_idx_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_idx <= LEN_C)
        else $error("read index beyond block length");

    a_ovr_needs_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovr) |-> $past(r_ready))
        else $error("overrun set without a pending block");

    a_no_put_in_ovr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovr |-> !i_cmd.put)
        else $error("sample written during overrun");

endmodule

// ===== rtl/ping_pong_sample_buffer_core.sv =====
// Ping-pong sample buffer: two banks of BLOCK_LEN signed 16-bit samples.
// Input channel (i_in_valid / o_in_stall / i_in_word) takes one word per
// action: put writes a sample into the active bank unless overrun is set,
// fetch streams the full bank out, status returns and clears the overrun flag.
// Output channel (o_out_valid / i_out_stall / o_out_word) returns result words.
// A put gives no word; puts may arrive every cycle while the input is not stalled.
// A fetch with a block ready gives BLOCK_LEN words, each through the memory
// read register then the output register, one per cycle while the receiver
// does not stall; the input stalls until the last read has moved to the
// output register. A fetch without a block and a status each give one word,
// valid in the next cycle.
// Receiver stall holds the output register and freezes the readout; new
// input words wait while the output register is stalled.
// Reset (synchronous, active low) clears the write pointer, bank selects, ready and
// overrun flags and both valids, and sets the read index to block end; sample memory is not cleared.
module ping_pong_sample_buffer_core
    import psb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_cmd cmd;
    t_sts sts;

    psb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_word.action),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    psb_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_sample    (i_in_word.sample),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== test/testbench.sv =====
// testbench for the ping-pong sample buffer core: directed table, then random fill and fetch traffic
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import psb_pkg::*;

    localparam int WORDS_WANTED = 230;
    localparam int QUIET_FROM   = 190;
    localparam t_out_word EMPTY_REPLY =
        '{sample_out: 16'sd0, available: 1'b0, last_sample: 1'b1, overflow_flag: 1'b0};

    typedef struct packed {
        t_in_word  w;
        logic      typed;
        t_out_word want;
    } t_row;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    ping_pong_sample_buffer_core i_dut (.*);

    always #5 i_clk = ~i_clk;

    // mirror of the buffer
    logic signed [15:0] bank_mem [2][BANK_DEPTH];
    int unsigned        fill_pos   = 0;
    bit                 fill_bank  = 1'b0;
    bit                 block_full = 1'b0;
    bit                 overrun_st = 1'b0;

    t_out_word due_replies [$];
    t_out_word fresh_replies [$];
    t_out_word head_reply;
    int        err_count  = 0;
    int        live_words = 0;
    int        words_out  = 0;
    int        blocks_out = 0;
    int        overruns   = 0;
    int        stall_left = 0;
    bit        quiet      = 1'b0;
    t_row      script [18];

    function automatic t_in_word word(t_action a, logic [15:0] s);
        return '{action: a, sample: s};
    endfunction

    // mostly puts, now and then any action
    function automatic t_in_word noisy_put();
        if ($urandom_range(0, 15) == 0)
            return word(t_action'($urandom_range(0, 3)), 16'($urandom));
        return word(ACT_PUT, 16'($urandom));
    endfunction

    // applies one accepted word to the mirror, its replies go to fresh_replies;
    // returns 1 when the block drops the word
    function automatic bit bank_step(t_in_word w);
        bit rd_bank;
        case (w.action)
            ACT_PUT: begin
                if (overrun_st) return 1'b1;
                bank_mem[fill_bank][fill_pos] = w.sample;
                if (fill_pos + 1 >= BLOCK_LEN) begin
                    fill_pos  = 0;
                    fill_bank = ~fill_bank;
                    if (block_full) begin
                        overrun_st = 1'b1;
                        overruns++;
                    end else begin
                        block_full = 1'b1;
                    end
                end else begin
                    fill_pos++;
                end
            end
            ACT_FETCH: begin
                if (!block_full) begin
                    fresh_replies.push_back(EMPTY_REPLY);
                end else begin
                    block_full = 1'b0;
                    // with an overrun pending the older bank goes out
                    rd_bank = (fill_bank == overrun_st);
                    for (int i = 0; i < BLOCK_LEN; i++)
                        fresh_replies.push_back(
                            '{bank_mem[rd_bank][i], 1'b1, i == BLOCK_LEN - 1, 1'b0});
                    blocks_out++;
                end
            end
            ACT_STATUS: begin
                fresh_replies.push_back('{16'sd0, 1'b0, 1'b1, overrun_st});
                overrun_st = 1'b0;
            end
            default: return 1'b1;
        endcase
        return 1'b0;
    endfunction

    task automatic send(t_in_word w, bit typed = 1'b0, t_out_word want = '0);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (o_in_stall);
        if (!bank_step(w)) live_words++;
        if (typed) due_replies.push_back(want);
        else due_replies = {due_replies, fresh_replies};
        fresh_replies.delete();
    endtask

    // hold the sender until every pending word is back
    task automatic drain();
        if (due_replies.size() != 0) begin
            i_in_valid <= 1'b0;
            while (due_replies.size() != 0) @(posedge i_clk);
        end
    endtask

    task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // random receiver stall bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            stall_left  <= $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            words_out++;
            if (due_replies.size() == 0) begin
                err_count++;
                $display("%0t: unexpected word, expected none, actual %h", $time, o_out_word);
            end else begin
                head_reply = due_replies.pop_front();
                check_field("sample_out", head_reply.sample_out, o_out_word.sample_out);
                check_field("available", head_reply.available, o_out_word.available);
                check_field("last_sample", head_reply.last_sample, o_out_word.last_sample);
                check_field("overflow_flag", head_reply.overflow_flag,
                            o_out_word.overflow_flag);
            end
        end
    end

    initial begin : stimulus
        int kind;
        int n;
        bit first;

        script = '{
            '{word(ACT_FETCH,  16'h0000), 1'b1, EMPTY_REPLY},   // nothing stored yet
            '{word(ACT_STATUS, 16'h1234), 1'b1, EMPTY_REPLY},
            '{word(ACT_NONE,   16'h7FFF), 1'b0, '0},
            '{word(ACT_PUT,    16'h7FFF), 1'b0, '0},
            '{word(ACT_PUT,    16'h8000), 1'b0, '0},
            '{word(ACT_PUT,    16'h0000), 1'b0, '0},
            '{word(ACT_PUT,    16'hFFFF), 1'b0, '0},
            '{word(ACT_PUT,    16'h0001), 1'b0, '0},
            '{word(ACT_FETCH,  16'hFFFF), 1'b1, EMPTY_REPLY},   // bank only partly filled
            '{word(ACT_STATUS, 16'h8000), 1'b1, EMPTY_REPLY},
            '{word(ACT_NONE,   16'h8000), 1'b0, '0},
            '{word(ACT_PUT,    16'h5555), 1'b0, '0},
            '{word(ACT_PUT,    16'hAAAA), 1'b0, '0},
            '{word(ACT_NONE,   16'h0000), 1'b0, '0},
            '{word(ACT_FETCH,  16'h5555), 1'b1, EMPTY_REPLY},
            '{word(ACT_PUT,    16'hFFFE), 1'b0, '0},
            '{word(ACT_STATUS, 16'hFFFF), 1'b1, EMPTY_REPLY},
            '{word(ACT_PUT,    16'h7FFF), 1'b0, '0}
        };

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) send(script[i].w, script[i].typed, script[i].want);

        drain();
        first = 1'b1;
        // full banks, block fetches and overruns all come from the random part
        while (live_words < WORDS_WANTED || overruns == 0 || blocks_out < 3) begin
            quiet = (live_words >= QUIET_FROM);
            kind  = first ? 6 : $urandom_range(0, 9);
            first = 1'b0;
            if (kind <= 5) begin
                n = BLOCK_LEN - int'(fill_pos) + int'($urandom_range(0, 4)) - 2;
                repeat (n) send(noisy_put());
                send(word(ACT_FETCH, 16'($urandom)));
            end else if (kind <= 7) begin
                // fill both banks without fetching, then poke at the overrun
                while (!overrun_st) send(word(ACT_PUT, 16'($urandom)));
                repeat ($urandom_range(1, 4)) send(word(ACT_PUT, 16'($urandom)));
                if ($urandom_range(0, 1)) send(word(ACT_STATUS, 16'($urandom)));
                send(word(ACT_FETCH, 16'($urandom)));
                send(word(ACT_FETCH, 16'($urandom)));
                send(word(ACT_STATUS, 16'($urandom)));
            end else if (kind == 8) begin
                repeat ($urandom_range(1, 6))
                    send(word(t_action'($urandom_range(0, 3)), 16'($urandom)));
            end else begin
                drain();
            end
        end

        i_in_valid <= 1'b0;
        while (due_replies.size() != 0) @(posedge i_clk);
        repeat (BLOCK_LEN + 8) @(posedge i_clk);

        $display("sent %0d live words, got %0d result words back", live_words, words_out);
        $display("%0d full blocks streamed out, overrun reached %0d times",
                 blocks_out, overruns);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timed out with %0d words still pending", due_replies.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
